// ===== rtl/core/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, codes and defaults of the PCM sample playback mixer.
// ----------------------------------------------------------------------------
package psm_pkg;

   // default configuration of the core
   localparam int CHANNELS_DEF   = 4;
   localparam int FRAC_BITS_DEF  = 10;
   localparam int ADDR_BITS_DEF  = 16;

   // depth of the command queue between front and back
   localparam int CMD_DEPTH      = 4;
   // depth of the result queue
   localparam int OUT_DEPTH      = 2;

   // input operation codes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_PLAY  = 3'd2;
   localparam logic [2:0] OP_STOP  = 3'd3;
   localparam logic [2:0] OP_NEXT  = 3'd4;
   localparam logic [2:0] OP_STEP  = 3'd5;
   localparam logic [2:0] OP_GAIN  = 3'd6;

   // control register indexes
   localparam logic CSR_PLAY_GAIN = 1'b0;
   localparam logic CSR_SOUND_OFF = 1'b1;

   localparam logic [11:0] PLAY_GAIN_RST = 12'd1024;
   localparam logic [7:0]  SILENCE       = 8'd128;
   localparam logic [7:0]  LEVEL_MAX     = 8'd255;

   // classified command kinds
   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_WRITE,
      CMD_PLAY,
      CMD_STOP,
      CMD_NEXT,
      CMD_STEP,
      CMD_GAIN
   } cmd_kind_type;

   // one queued command word
   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   channel;
      logic [15:0]  address;
      logic [16:0]  length;
      logic         repeat_req;
      logic [7:0]   sample_byte;
      logic [15:0]  rate_step;
      logic [11:0]  gain;
   } cmd_type;

endpackage

// ===== rtl/core/psm_front.sv =====
// ----------------------------------------------------------------------------
// psm_front
// Accepts input words, decodes the operation, drops words that do nothing
// and queues the rest for the back end.
// ----------------------------------------------------------------------------
module psm_front
   import psm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_channel,
   input  logic [15:0] req_address,
   input  logic [16:0] req_length,
   input  logic        req_repeat_req,
   input  logic [7:0]  req_sample_byte,
   input  logic [15:0] req_rate_step,
   input  logic [11:0] req_gain,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);
   localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

   cmd_type            q_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_kind_type       kind;
   logic               keep;
   logic               ch_ok;
   logic               push;
   cmd_type            word;

   // decode the operation
   always_comb begin
      keep = 1'b1;
      kind = CMD_TICK;
      unique case (req_op)
         OP_TICK:  kind = CMD_TICK;
         OP_WRITE: kind = CMD_WRITE;
         OP_PLAY:  kind = CMD_PLAY;
         OP_STOP:  kind = CMD_STOP;
         OP_NEXT:  kind = CMD_NEXT;
         OP_STEP:  kind = CMD_STEP;
         OP_GAIN:  kind = CMD_GAIN;
         default:  keep = 1'b0;
      endcase
   end

   // channel commands beyond the channel count are dropped here
   assign ch_ok = ({2'b00, req_channel} < CH_LIMIT);

   always_comb begin
      word             = '0;
      word.kind        = kind;
      word.channel     = req_channel;
      word.address     = req_address;
      word.length      = req_length;
      word.repeat_req  = req_repeat_req;
      word.sample_byte = req_sample_byte;
      word.rate_step   = req_rate_step;
      word.gain        = req_gain;
   end

   assign req_full  = (count_ff == CNT_W'(CMD_DEPTH));
   assign push      = req_push && !req_full && keep &&
                      (kind == CMD_TICK || kind == CMD_WRITE || ch_ok);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_take ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== rtl/core/psm_back.sv =====
// ----------------------------------------------------------------------------
// psm_back
// Executes queued commands: sample memory, per-channel playback state,
// the tick mixer that walks the channels one per cycle, and the result queue.
// ----------------------------------------------------------------------------
module psm_back
   import psm_pkg::*;
#(
   parameter int CHANNELS         = CHANNELS_DEF,
   parameter int FRAC_BITS        = FRAC_BITS_DEF,
   parameter int SAMPLE_ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_pwm_level,
   output logic [3:0]  rsp_active_mask
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW     = SAMPLE_ADDR_BITS;
   localparam int ACC_W  = 17;
   localparam int SUM_W  = ((FRAC_BITS + 8 > 23) ? FRAC_BITS + 8 : 23) + 2;
   localparam int LVL_W  = SUM_W - FRAC_BITS;
   localparam int OP_W   = $clog2(OUT_DEPTH);
   localparam int OC_W   = $clog2(OUT_DEPTH + 1);
   localparam logic [CH_W-1:0]         LAST_CH = CH_W'(CHANNELS - 1);
   localparam logic signed [SUM_W-1:0] BIAS    = SUM_W'(SILENCE) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

   // control registers
   logic [11:0]            play_gain_ff;
   logic                   sound_off_ff;

   // per-channel playback state
   logic [AW-1:0]          cur_ff     [CHANNELS];
   logic [16:0]            rem_ff     [CHANNELS];
   logic [AW-1:0]          nxt_addr_ff[CHANNELS];
   logic [16:0]            nxt_cnt_ff [CHANNELS];
   logic [15:0]            step_ff    [CHANNELS];
   logic [FRAC_BITS-1:0]   phase_ff   [CHANNELS];
   logic [11:0]            gain_ff    [CHANNELS];

   logic [CH_W-1:0]        sel;
   logic [AW-1:0]          cur_sel, cur_in;
   logic [16:0]            rem_sel, rem_in;
   logic [AW-1:0]          nxt_addr_sel, nxt_addr_in;
   logic [16:0]            nxt_cnt_sel, nxt_cnt_in;
   logic [15:0]            step_sel, step_in;
   logic [FRAC_BITS-1:0]   phase_sel, phase_in;
   logic [11:0]            gain_sel, gain_in;
   logic                   ch_we;

   // sequencer and mixer
   state_type              state_ff, state_in;
   logic [CH_W-1:0]        idx_ff, idx_in;
   logic [CHANNELS-1:0]    mask_ff, mask_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                   pvld_ff, pvld_in;
   logic [11:0]            pgain_ff, pgain_in;
   logic [7:0]             rd_ff;
   logic                   rd_en;
   logic                   mem_we;
   logic [AW-1:0]          cmd_addr;
   logic [7:0]             mem [2**AW];

   logic [ACC_W-1:0]       acc;
   logic [ACC_W-1:0]       whole;
   logic                   active;
   logic                   skip_next;
   logic signed [8:0]      sample_s;
   logic signed [12:0]     gain_s;
   logic signed [21:0]     prod;
   logic signed [SUM_W-1:0] addend;
   logic signed [SUM_W-1:0] total;
   logic [LVL_W-1:0]       lvl_full;
   logic [7:0]             level;
   logic [CHANNELS+3:0]    mask_pad;

   // result queue
   logic                   push;
   logic [7:0]             push_level;
   logic [3:0]             push_mask;
   logic                   pop;
   logic [7:0]             out_lvl_ff [OUT_DEPTH];
   logic [3:0]             out_msk_ff [OUT_DEPTH];
   logic [OP_W-1:0]        out_wp_ff, out_rp_ff;
   logic [OC_W-1:0]        out_cnt_ff;

   // channel selection: walker index while scanning, command channel otherwise
   assign sel          = (state_ff == ST_SCAN) ? idx_ff : CH_W'(cmd.channel);
   assign cur_sel      = cur_ff[sel];
   assign rem_sel      = rem_ff[sel];
   assign nxt_addr_sel = nxt_addr_ff[sel];
   assign nxt_cnt_sel  = nxt_cnt_ff[sel];
   assign step_sel     = step_ff[sel];
   assign phase_sel    = phase_ff[sel];
   assign gain_sel     = gain_ff[sel];
   assign cmd_addr     = AW'(cmd.address);

   // pointer advance
   assign acc    = ACC_W'(phase_sel) + ACC_W'(step_sel);
   assign whole  = acc >> FRAC_BITS;
   assign active = (rem_sel != '0);

   assign skip_next = !sound_off_ff && active && (nxt_addr_sel == cmd_addr) &&
                      (nxt_cnt_sel == cmd.length);

   // multiply-accumulate on the sample read in the previous cycle
   assign sample_s = $signed({1'b0, rd_ff}) - $signed({1'b0, SILENCE});
   assign gain_s   = $signed({1'b0, pgain_ff});
   assign prod     = sample_s * gain_s;
   assign addend   = pvld_ff ? {{(SUM_W - 22){prod[21]}}, prod} : '0;
   assign total    = sum_ff + addend;

   // shift down and clamp
   assign lvl_full = total[SUM_W-1:FRAC_BITS];
   always_comb begin
      if (total[SUM_W-1]) begin
         level = '0;
      end else if (lvl_full > LVL_W'(LEVEL_MAX)) begin
         level = LEVEL_MAX;
      end else begin
         level = lvl_full[7:0];
      end
   end

   assign mask_pad = {4'b0000, mask_ff};

   // command sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      mask_in     = mask_ff;
      sum_in      = sum_ff;
      pvld_in     = 1'b0;
      pgain_in    = pgain_ff;
      rd_en       = 1'b0;
      mem_we      = 1'b0;
      cmd_take    = 1'b0;
      push        = 1'b0;
      push_level  = '0;
      push_mask   = '0;
      ch_we       = 1'b0;
      cur_in      = cur_sel;
      rem_in      = rem_sel;
      nxt_addr_in = nxt_addr_sel;
      nxt_cnt_in  = nxt_cnt_sel;
      step_in     = step_sel;
      phase_in    = phase_sel;
      gain_in     = gain_sel;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_TICK: begin
                     // start only with room for the result
                     if (out_cnt_ff != OC_W'(OUT_DEPTH)) begin
                        cmd_take = 1'b1;
                        if (sound_off_ff) begin
                           push = 1'b1;
                        end else begin
                           state_in = ST_SCAN;
                           idx_in   = '0;
                           sum_in   = BIAS;
                           mask_in  = '0;
                        end
                     end
                  end
                  CMD_WRITE: begin
                     cmd_take = 1'b1;
                     mem_we   = 1'b1;
                  end
                  CMD_PLAY: begin
                     cmd_take = 1'b1;
                     if (!sound_off_ff) begin
                        ch_we      = 1'b1;
                        nxt_cnt_in = cmd.repeat_req ? cmd.length : '0;
                        if (cmd.repeat_req) begin
                           nxt_addr_in = cmd_addr;
                        end
                        step_in  = cmd.rate_step;
                        phase_in = '0;
                        gain_in  = play_gain_ff;
                        cur_in   = cmd_addr;
                        rem_in   = cmd.length;
                     end
                  end
                  CMD_STOP: begin
                     cmd_take = 1'b1;
                     ch_we    = 1'b1;
                     rem_in   = '0;
                  end
                  CMD_NEXT: begin
                     cmd_take = 1'b1;
                     if (!skip_next) begin
                        ch_we = 1'b1;
                        // an idle channel starts on the queued sound at once
                        if (!active) begin
                           cur_in = cmd_addr;
                           rem_in = cmd.length;
                        end
                        nxt_addr_in = cmd_addr;
                        nxt_cnt_in  = cmd.length;
                     end
                  end
                  CMD_STEP: begin
                     cmd_take = 1'b1;
                     ch_we    = 1'b1;
                     step_in  = cmd.rate_step;
                  end
                  CMD_GAIN: begin
                     cmd_take = 1'b1;
                     ch_we    = 1'b1;
                     gain_in  = cmd.gain;
                  end
                  default: begin
                     cmd_take = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one channel per cycle: fetch its sample, advance its pointer
            sum_in          = total;
            rd_en           = 1'b1;
            pvld_in         = active;
            pgain_in        = gain_sel;
            mask_in[idx_ff] = active;
            if (active) begin
               ch_we    = 1'b1;
               phase_in = acc[FRAC_BITS-1:0];
               if (whole >= rem_sel) begin
                  rem_in = nxt_cnt_sel;
                  cur_in = nxt_addr_sel;
               end else begin
                  rem_in = rem_sel - whole;
                  cur_in = cur_sel + AW'(whole);
               end
            end
            if (idx_ff == LAST_CH) begin
               state_in = ST_SUM;
            end else begin
               idx_in = idx_ff + CH_W'(1);
            end
         end
         ST_SUM: begin
            // last product lands here; no active channel gives level zero
            push       = 1'b1;
            push_level = (mask_ff == '0) ? 8'd0 : level;
            push_mask  = mask_pad[3:0];
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer registers and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         mask_ff      <= '0;
         pvld_ff      <= 1'b0;
         play_gain_ff <= PLAY_GAIN_RST;
         sound_off_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         mask_ff  <= mask_in;
         pvld_ff  <= pvld_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PLAY_GAIN: play_gain_ff <= csr_wdata;
               CSR_SOUND_OFF: sound_off_ff <= csr_wdata[0];
               default:       ;
            endcase
         end
      end
   end

   // mixer datapath
   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      pgain_ff <= pgain_in;
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            cur_ff[i]      <= '0;
            rem_ff[i]      <= '0;
            nxt_addr_ff[i] <= '0;
            nxt_cnt_ff[i]  <= '0;
            step_ff[i]     <= '0;
            phase_ff[i]    <= '0;
            gain_ff[i]     <= '0;
         end
      end else if (ch_we) begin
         cur_ff[sel]      <= cur_in;
         rem_ff[sel]      <= rem_in;
         nxt_addr_ff[sel] <= nxt_addr_in;
         nxt_cnt_ff[sel]  <= nxt_cnt_in;
         step_ff[sel]     <= step_in;
         phase_ff[sel]    <= phase_in;
         gain_ff[sel]     <= gain_in;
      end
   end

   // sample memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_addr] <= cmd.sample_byte;
      end
      if (rd_en) begin
         rd_ff <= mem[cur_sel];
      end
   end

   // result queue
   assign rsp_empty       = (out_cnt_ff == '0);
   assign pop             = rsp_pop && !rsp_empty;
   assign rsp_pwm_level   = out_lvl_ff[out_rp_ff];
   assign rsp_active_mask = out_msk_ff[out_rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wp_ff  <= '0;
         out_rp_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (push) begin
            out_wp_ff <= out_wp_ff + OP_W'(1);
         end
         if (pop) begin
            out_rp_ff <= out_rp_ff + OP_W'(1);
         end
         out_cnt_ff <= out_cnt_ff + OC_W'(push) - OC_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_lvl_ff[out_wp_ff] <= push_level;
         out_msk_ff[out_wp_ff] <= push_mask;
      end
   end

   // checks
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OC_W'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_cnt_ff != OC_W'(OUT_DEPTH))
      else $error("result pushed into a full queue");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("command taken from an empty queue");

   a_sum_push: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> state_ff == ST_IDLE && $past(push))
      else $error("tick finished without a result");

   a_scan_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= LAST_CH)
      else $error("channel walker out of range");

endmodule

// ===== rtl/core/pcm_sample_playback_mixer_core.sv =====
// ----------------------------------------------------------------------------
// pcm_sample_playback_mixer_core
// Multichannel 8-bit PCM player producing a PWM level per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive req_* and raise req_push while req_full is
//   low. Each word writes a sample byte, controls a channel, or is a tick.
//   Only a tick yields a result word, read from the rsp side: it is valid
//   while rsp_empty is low and is removed by rsp_pop.
//   The csr port writes play gain (index 0) and the global mute (index 1);
//   write it only while the core is idle.
// Timing:
//   A word enters a 4-deep command queue and is executed in order. A tick
//   starts in the idle state, walks one channel per cycle through the single
//   sample memory read port, then ends in a final sum state; a muted tick
//   pushes its result straight from the idle state.
//   The result is visible the cycle after the tick completes.
// Reset (synchronous): clears queues and channel state, play gain to 1024,
//   mute off. Sample memory is not cleared.
// Stall: results wait in a 2-deep queue; when it is full the next tick
//   holds in the command queue and req_full rises once that fills too.
// ----------------------------------------------------------------------------
module pcm_sample_playback_mixer_core
   import psm_pkg::*;
#(
   parameter int CHANNELS         = CHANNELS_DEF,
   parameter int FRAC_BITS        = FRAC_BITS_DEF,
   parameter int SAMPLE_ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_channel,
   input  logic [15:0] req_address,
   input  logic [16:0] req_length,
   input  logic        req_repeat_req,
   input  logic [7:0]  req_sample_byte,
   input  logic [15:0] req_rate_step,
   input  logic [11:0] req_gain,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_pwm_level,
   output logic [3:0]  rsp_active_mask,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   // accept and decode
   psm_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_channel    (req_channel),
      .req_address    (req_address),
      .req_length     (req_length),
      .req_repeat_req (req_repeat_req),
      .req_sample_byte(req_sample_byte),
      .req_rate_step  (req_rate_step),
      .req_gain       (req_gain),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd)
   );

   // execute and mix
   psm_back #(
      .CHANNELS        (CHANNELS),
      .FRAC_BITS       (FRAC_BITS),
      .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pwm_level  (rsp_pwm_level),
      .rsp_active_mask(rsp_active_mask)
   );

endmodule

// ===== tb/pcm_mixer_checker.sv =====
// ----------------------------------------------------------------------------
// pcm_mixer_checker
// Watches the request, result and csr ports of the PCM playback mixer core,
// keeps its own copy of the channel state and sample memory, works out the
// level and channel mask of every accepted tick, and compares each popped
// result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pcm_mixer_checker
   import psm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_channel,
   input  logic [15:0] req_address,
   input  logic [16:0] req_length,
   input  logic        req_repeat_req,
   input  logic [7:0]  req_sample_byte,
   input  logic [15:0] req_rate_step,
   input  logic [11:0] req_gain,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_pwm_level,
   input  logic [3:0]  rsp_active_mask,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   output int          error_count,
   output int          expected_count
);

   localparam int NCH  = CHANNELS_DEF;
   localparam int FRAC = FRAC_BITS_DEF;

   typedef struct packed {
      logic [7:0] level;
      logic [3:0] mask;
   } mix_word_type;

   // predicted mixer state
   logic [7:0]      sample_mem [0:65535];
   logic [15:0]     play_addr  [NCH];
   logic [16:0]     play_left  [NCH];
   logic [15:0]     queued_addr[NCH];
   logic [16:0]     queued_left[NCH];
   logic [15:0]     step_q     [NCH];
   logic [FRAC-1:0] phase_acc  [NCH];
   logic [11:0]     chan_gain  [NCH];
   logic [11:0]     gain_on_play;
   logic            muted;

   mix_word_type    levels_q[$];
   int              errors = 0;

   // mix one tick and advance every playing channel
   function automatic mix_word_type mix_one_tick();
      mix_word_type res;
      int           sum;
      int           lvl;
      logic [16:0]  acc;
      logic [16:0]  whole;
      res = '0;
      if (muted) return res;
      sum = 128 << FRAC;
      for (int c = 0; c < NCH; c++) begin
         if (play_left[c] == 0) continue;
         res.mask[c] = 1'b1;
         sum += (int'(sample_mem[play_addr[c]]) - 128) * int'(chan_gain[c]);
         acc = 17'(phase_acc[c]) + 17'(step_q[c]);
         whole = acc >> FRAC;
         phase_acc[c] = acc[FRAC-1:0];
         if (whole >= play_left[c]) begin
            // sound ran out: chain to the queued one (count 0 stops)
            play_left[c] = queued_left[c];
            play_addr[c] = queued_addr[c];
         end else begin
            play_left[c] = play_left[c] - whole;
            play_addr[c] = play_addr[c] + whole[15:0];
         end
      end
      if (res.mask != 0 && sum >= 0) begin
         lvl = sum >>> FRAC;
         res.level = (lvl > 255) ? LEVEL_MAX : lvl[7:0];
      end
      return res;
   endfunction

   // apply one accepted request word
   task automatic run_command();
      int ch;
      ch = req_channel;
      case (req_op)
         OP_TICK:  levels_q.push_back(mix_one_tick());
         OP_WRITE: sample_mem[req_address] = req_sample_byte;
         OP_PLAY: begin
            if (!muted) begin
               queued_left[ch] = '0;
               if (req_repeat_req) begin
                  queued_addr[ch] = req_address;
                  queued_left[ch] = req_length;
               end
               step_q[ch]    = req_rate_step;
               phase_acc[ch] = '0;
               chan_gain[ch] = gain_on_play;
               play_addr[ch] = req_address;
               play_left[ch] = req_length;
            end
         end
         OP_STOP: play_left[ch] = '0;
         OP_NEXT: begin
            // same sound already queued on a playing channel while unmuted: no change
            if (muted || play_left[ch] == 0 || queued_addr[ch] != req_address ||
                queued_left[ch] != req_length) begin
               if (play_left[ch] == 0) begin
                  play_addr[ch] = req_address;
                  play_left[ch] = req_length;
               end
               queued_addr[ch] = req_address;
               queued_left[ch] = req_length;
            end
         end
         OP_STEP: step_q[ch] = req_rate_step;
         OP_GAIN: chan_gain[ch] = req_gain;
         default: ;
      endcase
   endtask

   // observe all three ports at each rising edge
   always @(posedge clock) begin
      mix_word_type got;
      mix_word_type want;
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            play_addr[c]   = '0;
            play_left[c]   = '0;
            queued_addr[c] = '0;
            queued_left[c] = '0;
            step_q[c]      = '0;
            phase_acc[c]   = '0;
            chan_gain[c]   = '0;
         end
         gain_on_play = PLAY_GAIN_RST;
         muted        = 1'b0;
         levels_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PLAY_GAIN) gain_on_play = csr_wdata;
            else muted = csr_wdata[0];
         end
         // results first: a tick accepted on this edge cannot answer yet
         if (rsp_pop && !rsp_empty) begin
            got.level = rsp_pwm_level;
            got.mask  = rsp_active_mask;
            if (levels_q.size() == 0) begin
               errors++;
               $error("result word with no tick pending: pwm_level %0d active_mask %0h",
                      got.level, got.mask);
            end else begin
               want = levels_q.pop_front();
               if (got.level !== want.level) begin
                  errors++;
                  $error("pwm_level: expected %0d, actual %0d", want.level, got.level);
               end
               if (got.mask !== want.mask) begin
                  errors++;
                  $error("active_mask: expected %0h, actual %0h", want.mask, got.mask);
               end
            end
         end
         if (req_push && !req_full) run_command();
      end
      error_count    <= errors;
      expected_count <= levels_q.size();
   end

endmodule

// ===== tb/pcm_sample_playback_mixer_core_test.sv =====
// ----------------------------------------------------------------------------
// pcm_sample_playback_mixer_core_test
// Fills a window of the sample memory across the address wrap, runs a
// directed set of mixer commands (clamping, wrap, chaining, mute, unused op),
// then phases of random commands whose sounds stay inside that window, under
// several play gain and mute settings with random idling on both ports.
// Checking is done by the pcm_mixer_checker beside the core.
// ----------------------------------------------------------------------------
module pcm_sample_playback_mixer_core_test;
   import psm_pkg::*;

   localparam logic [2:0] OP_UNUSED   = 3'd7;
   localparam int SETTLE_CYCLES       = 24;
   localparam int WATCHDOG_LIMIT      = 1000;
   localparam int PHASES              = 6;
   localparam int WORDS_PER_PHASE     = 194;
   // filled sample window, wrapping past the top address
   localparam logic [15:0] WIN_BASE   = 16'hFFC0;
   localparam int WIN_SIZE            = 256;
   // longest random sound, so start plus length stays in the window
   localparam int MAX_LEN             = 48;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_op;
   logic [1:0]  req_channel;
   logic [15:0] req_address;
   logic [16:0] req_length;
   logic        req_repeat_req;
   logic [7:0]  req_sample_byte;
   logic [15:0] req_rate_step;
   logic [11:0] req_gain;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_pwm_level;
   logic [3:0]  rsp_active_mask;
   logic        csr_we;
   logic        csr_index;
   logic [11:0] csr_wdata;

   int          error_count;
   int          expected_count;
   int          idle_cycles = 0;

   // pacing state of both sides
   bit          fill_mode = 1'b0;
   bit          tx_calm, rx_calm;
   int          tx_run = 0, rx_run = 0;

   // last sound queued per channel, reused to hit the already-queued case
   logic [15:0] hint_addr[4];
   logic [16:0] hint_len[4];

   pcm_sample_playback_mixer_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_address     (req_address),
      .req_length      (req_length),
      .req_repeat_req  (req_repeat_req),
      .req_sample_byte (req_sample_byte),
      .req_rate_step   (req_rate_step),
      .req_gain        (req_gain),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pwm_level   (rsp_pwm_level),
      .rsp_active_mask (rsp_active_mask),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   pcm_mixer_checker mixer_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_address     (req_address),
      .req_length      (req_length),
      .req_repeat_req  (req_repeat_req),
      .req_sample_byte (req_sample_byte),
      .req_rate_step   (req_rate_step),
      .req_gain        (req_gain),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pwm_level   (rsp_pwm_level),
      .rsp_active_mask (rsp_active_mask),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .expected_count  (expected_count)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // gap before each word: random 0..9, with stretches of no idling
   function automatic int sender_gap();
      if (fill_mode) return 0;
      if (tx_run == 0) begin
         tx_run  = $urandom_range(20, 80);
         tx_calm = ($urandom_range(0, 3) == 0);
      end
      tx_run--;
      return tx_calm ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic int receiver_gap();
      if (rx_run == 0) begin
         rx_run  = $urandom_range(20, 80);
         rx_calm = ($urandom_range(0, 3) == 0);
      end
      rx_run--;
      return rx_calm ? 0 : $urandom_range(0, 9);
   endfunction

   // push one request word and wait until it is taken
   task automatic send_word(input logic [2:0] op, input logic [1:0] ch,
                            input logic [15:0] addr, input logic [16:0] len,
                            input logic rep, input logic [7:0] sbyte,
                            input logic [15:0] step, input logic [11:0] gain);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op          <= op;
      req_channel     <= ch;
      req_address     <= addr;
      req_length      <= len;
      req_repeat_req  <= rep;
      req_sample_byte <= sbyte;
      req_rate_step   <= step;
      req_gain        <= gain;
      req_push        <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   // short form for commands whose other fields are don't-care
   task automatic send_cmd(input logic [2:0] op, input logic [1:0] ch,
                           input logic [15:0] addr, input logic [16:0] len,
                           input logic rep, input logic [15:0] step,
                           input logic [11:0] gain);
      send_word(op, ch, addr, len, rep, 8'($urandom_range(0, 255)), step, gain);
   endtask

   // hold off until all results are in and the command queue has drained
   task automatic drain_and_settle();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [11:0] data);
      drain_and_settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // one random command, mostly well formed, small lengths and steps
   task automatic send_random_word();
      int          pick;
      logic [2:0]  op;
      logic [1:0]  ch;
      logic [15:0] addr;
      logic [16:0] len;
      logic        rep;
      logic [15:0] step;
      pick = $urandom_range(0, 99);
      ch   = 2'($urandom_range(0, 3));
      addr = 16'($urandom_range(0, 65535));
      rep  = 1'($urandom_range(0, 1));
      if (pick < 35)      op = OP_TICK;
      else if (pick < 50) op = OP_WRITE;
      else if (pick < 65) op = OP_PLAY;
      else if (pick < 75) op = OP_NEXT;
      else if (pick < 80) op = OP_STOP;
      else if (pick < 88) op = OP_STEP;
      else if (pick < 96) op = OP_GAIN;
      else                op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) len = '0;
      else                           len = 17'($urandom_range(1, MAX_LEN));
      // a sound never reads past its start plus length, so keep it in the window
      if (op == OP_PLAY || op == OP_NEXT) begin
         addr = WIN_BASE + 16'($urandom_range(0, WIN_SIZE - MAX_LEN));
      end else if (op == OP_WRITE && $urandom_range(0, 1) == 1) begin
         addr = WIN_BASE + 16'($urandom_range(0, WIN_SIZE - 1));
      end
      step = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 3072));
      if (op == OP_NEXT && $urandom_range(0, 1)) begin
         addr = hint_addr[ch];
         len  = hint_len[ch];
      end
      if (op == OP_NEXT || (op == OP_PLAY && rep)) begin
         hint_addr[ch] = addr;
         hint_len[ch]  = len;
      end
      send_word(op, ch, addr, len, rep, 8'($urandom_range(0, 255)), step,
                12'($urandom_range(0, 4095)));
   endtask

   // result side: pop with random stalls
   initial begin
      int gap;
      rsp_pop = 1'b0;
      forever begin
         gap = receiver_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      logic [11:0] gain_pick;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_op          = OP_TICK;
      req_channel     = '0;
      req_address     = '0;
      req_length      = '0;
      req_repeat_req  = 1'b0;
      req_sample_byte = '0;
      req_rate_step   = '0;
      req_gain        = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_PLAY_GAIN;
      csr_wdata       = '0;
      for (int c = 0; c < 4; c++) begin
         hint_addr[c] = '0;
         hint_len[c]  = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fill the sample window so every playback read is defined
      fill_mode = 1'b1;
      for (int a = 0; a < WIN_SIZE; a++)
         send_word(OP_WRITE, 2'($urandom_range(0, 3)), WIN_BASE + a[15:0],
                   17'($urandom_range(0, 131071)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   12'($urandom_range(0, 4095)));
      fill_mode = 1'b0;

      // directed: nothing active, then clamp high on full-scale samples
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      send_word(OP_WRITE, 0, 16'h0010, 0, 0, 8'h00, 0, 0);
      send_word(OP_WRITE, 0, 16'h0020, 0, 0, 8'hFF, 0, 0);
      send_cmd(OP_PLAY, 0, 16'h0020, 5, 0, 0, 0);
      send_cmd(OP_GAIN, 0, 0, 0, 0, 0, 12'hFFF);
      send_cmd(OP_PLAY, 1, 16'h0020, 1, 1, 0, 0);
      send_cmd(OP_GAIN, 1, 0, 0, 0, 0, 12'hFFF);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      // negative sum clamps to zero
      send_cmd(OP_PLAY, 2, 16'h0010, 7, 0, 0, 0);
      send_cmd(OP_GAIN, 2, 0, 0, 0, 0, 12'hFFF);
      send_cmd(OP_STOP, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_STOP, 1, 0, 0, 0, 0, 0);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      // address wrap at the top, largest step and length
      send_cmd(OP_PLAY, 3, 16'hFFFF, 17'd65536, 1, 16'hFFFF, 0);
      send_cmd(OP_NEXT, 2, 16'hFFFE, 17'h1FFFF, 0, 0, 0);
      send_cmd(OP_NEXT, 2, 16'hFFFE, 17'h1FFFF, 0, 0, 0);
      send_cmd(OP_STOP, 2, 0, 0, 0, 0, 0);
      // set next on an idle channel starts it; short sound chains to itself
      send_word(OP_WRITE, 0, 16'h8000, 0, 0, 8'h40, 0, 0);
      send_cmd(OP_NEXT, 1, 16'h8000, 1, 0, 0, 0);
      send_cmd(OP_STEP, 1, 0, 0, 0, 16'd1024, 0);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_PLAY, 0, 16'h1234, 0, 1, 16'd512, 0);
      send_cmd(OP_UNUSED, 3, 16'hFFFF, 17'h1FFFF, 1, 16'hFFFF, 12'hFFF);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);

      // directed mute: play ignored, tick frozen, queued next not seen
      write_reg(CSR_SOUND_OFF, 12'h001);
      send_cmd(OP_PLAY, 0, 16'h0020, 9, 1, 16'd2048, 0);
      send_cmd(OP_NEXT, 1, 16'h8000, 1, 0, 0, 0);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      write_reg(CSR_SOUND_OFF, 12'hFFE);
      send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0);
      // the long sound on channel 3 would run out of the window
      send_cmd(OP_STOP, 3, 0, 0, 0, 0, 0);

      // random phases over play gain and mute settings
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       gain_pick = PLAY_GAIN_RST;
            1:       gain_pick = 12'h000;
            2:       gain_pick = 12'hFFF;
            default: gain_pick = 12'($urandom_range(0, 4095));
         endcase
         write_reg(CSR_PLAY_GAIN, gain_pick);
         write_reg(CSR_SOUND_OFF, {11'($urandom_range(0, 2047)), p == 3});
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            send_random_word();
            if (i % 100 == 99) drain_and_settle();
         end
      end

      drain_and_settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== pcm_sample_playback_mixer_core.f =====
rtl/core/psm_pkg.sv
rtl/core/psm_front.sv
rtl/core/psm_back.sv
rtl/core/pcm_sample_playback_mixer_core.sv
tb/pcm_mixer_checker.sv
tb/pcm_sample_playback_mixer_core_test.sv
